// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SMPQ_ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion on the local clk and rst_n.
`define SMPQ_ASSERT(lbl, prop) \
    `SMPQ_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// ===== design/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Constants and types of the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_NOP  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== design/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell
// One entry of the sorted store: compares against the incoming value and
// takes its own, its neighbour's or the new value on each transaction.
// ----------------------------------------------------------------------------
module smpq_cell
(
    input  logic                                clk,
    input  smpq_pkg::cell_ctrl_t                ctrl,
    input  logic                                occupied,
    input  logic signed [smpq_pkg::DATA_W-1:0]  value,
    input  logic signed [smpq_pkg::DATA_W-1:0]  prev_entry,
    input  logic                                prev_less,
    input  logic signed [smpq_pkg::DATA_W-1:0]  next_entry,
    output logic signed [smpq_pkg::DATA_W-1:0]  entry,
    output logic signed [smpq_pkg::DATA_W-1:0]  entry_next,
    output logic                                less
);

    logic signed [smpq_pkg::DATA_W-1:0] entry_reg;

    assign less  = occupied && (entry_reg < value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push)
        begin
            priority if (less)
                entry_next = entry_reg;
            else if (prev_less)
                entry_next = value;
            else
                entry_next = prev_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== design/sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded minimum priority queue of signed 32-bit values held in ascending
// order across a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// cmd      in         cmd_valid/cmd_stall  opcode, value
// rsp      out        rsp_valid/rsp_stall  front_value, entry_count, is_empty,
//                                          is_full, status
//
// One transaction per cycle while cmd_stall is low; its result shows the cycle after acceptance.
// Every cell compares and shifts in parallel, so the clock period is set by
// one 32-bit compare and the insert select in each cell.
// Reset clears the count and the result valid; stored entries are not cleared.
// cmd_stall is high while a result is held and rsp_stall is high.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          opcode,
    input  logic signed [smpq_pkg::DATA_W-1:0]  value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [smpq_pkg::DATA_W-1:0]  front_value,
    output logic [smpq_pkg::COUNT_W-1:0]        entry_count,
    output logic                                is_empty,
    output logic                                is_full,
    output logic [1:0]                          status
);

    logic                               accept;
    logic                               is_push;
    logic                               is_pop;
    logic                               full_now;
    logic                               empty_now;
    smpq_pkg::cell_ctrl_t               ctrl;
    smpq_pkg::status_t                  status_next;

    logic [smpq_pkg::CNT_W-1:0]         count_reg;
    logic [smpq_pkg::CNT_W-1:0]         count_next;
    logic [smpq_pkg::CNT_W+smpq_pkg::COUNT_W-1:0] count_wide;

    logic signed [smpq_pkg::DATA_W-1:0] entries      [smpq_pkg::CAPACITY];
    logic signed [smpq_pkg::DATA_W-1:0] entries_next [smpq_pkg::CAPACITY];
    logic                               less         [smpq_pkg::CAPACITY];

    logic                               rsp_valid_reg;
    logic signed [smpq_pkg::DATA_W-1:0] front_value_reg;
    logic signed [smpq_pkg::DATA_W-1:0] front_value_next;
    logic [smpq_pkg::COUNT_W-1:0]       entry_count_reg;
    logic                               is_empty_reg;
    logic                               is_full_reg;
    smpq_pkg::status_t                  status_reg;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign is_push   = (opcode == smpq_pkg::OP_PUSH);
    assign is_pop    = (opcode == smpq_pkg::OP_POP);
    assign full_now  = (count_reg == smpq_pkg::CNT_W'(smpq_pkg::CAPACITY));
    assign empty_now = (count_reg == '0);

    assign ctrl.push = accept && is_push && !full_now;
    assign ctrl.pop  = accept && is_pop && !empty_now;

    always_comb
    begin
        status_next = smpq_pkg::ST_OK;
        priority if (is_push && full_now)
            status_next = smpq_pkg::ST_FULL;
        else if (is_pop && empty_now)
            status_next = smpq_pkg::ST_EMPTY;
        else
            status_next = smpq_pkg::ST_OK;
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ctrl.push)
            count_next = count_reg + smpq_pkg::CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - smpq_pkg::CNT_W'(1);
        else
            count_next = count_reg;
    end

    generate
        for (genvar i = 0; i < smpq_pkg::CAPACITY; i++)
        begin : g_cell
            logic signed [smpq_pkg::DATA_W-1:0] prev_entry;
            logic                               prev_less;
            logic signed [smpq_pkg::DATA_W-1:0] next_entry;

            if (i == 0)
            begin : g_head
                assign prev_entry = value;
                assign prev_less  = 1'b1;
            end
            else
            begin : g_body
                assign prev_entry = entries[i-1];
                assign prev_less  = less[i-1];
            end

            if (i == smpq_pkg::CAPACITY - 1)
            begin : g_tail
                assign next_entry = entries[i];
            end
            else
            begin : g_inner
                assign next_entry = entries[i+1];
            end

            smpq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count_reg > smpq_pkg::CNT_W'(i)),
                .value      (value),
                .prev_entry (prev_entry),
                .prev_less  (prev_less),
                .next_entry (next_entry),
                .entry      (entries[i]),
                .entry_next (entries_next[i]),
                .less       (less[i])
            );
        end
    endgenerate

    assign front_value_next = (count_next == '0) ? '0 : entries_next[0];
    assign count_wide       = {{smpq_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_value_reg <= front_value_next;
            entry_count_reg <= count_wide[smpq_pkg::COUNT_W-1:0];
            is_empty_reg    <= (count_next == '0);
            is_full_reg     <= (count_next == smpq_pkg::CNT_W'(smpq_pkg::CAPACITY));
            status_reg      <= status_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign front_value = front_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;
    assign status      = status_reg;

endmodule

// ===== design/smpq_checker.sv =====
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks of the sorted minimum priority queue, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smpq_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cmd_valid,
    input logic                                cmd_stall,
    input logic [1:0]                          opcode,
    input logic signed [smpq_pkg::DATA_W-1:0]  value,
    input logic                                rsp_valid,
    input logic                                rsp_stall,
    input logic signed [smpq_pkg::DATA_W-1:0]  front_value,
    input logic [smpq_pkg::COUNT_W-1:0]        entry_count,
    input logic                                is_empty,
    input logic                                is_full,
    input logic [1:0]                          status
);

    `SMPQ_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable({front_value, status}))

    `SMPQ_ASSERT(a_empty_count, rsp_valid |-> (is_empty == (entry_count == '0)))

    `SMPQ_ASSERT(a_empty_front, rsp_valid && is_empty |-> (front_value == '0))

    `SMPQ_ASSERT(a_drop_full, rsp_valid && (status == smpq_pkg::ST_FULL) |-> is_full)

    `SMPQ_ASSERT(a_pop_empty, rsp_valid && (status == smpq_pkg::ST_EMPTY) |-> is_empty)

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);
